// ----- sv/bba_pkg.sv -----
package bba_pkg;

  localparam int MIN_SHIFT    = 5;
  localparam int NUM_LEVELS   = 8;
  localparam int POOL_BYTES   = 4096;
  localparam int HEADER_BYTES = 24;

  localparam int LVL_W      = 3;
  localparam int IDX_W      = NUM_LEVELS - 1;
  localparam int MIN_BLOCKS = 1 << IDX_W;
  localparam int ADDR_W     = 12;
  localparam int BYTES_W    = 13;
  localparam int TOTAL_W    = BYTES_W + 1;
  localparam int STATUS_W   = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_ZERO  = 2'd1,
    ST_NOFIT = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SEARCH,
    S_SPLIT,
    S_GRANT,
    S_LOOKUP,
    S_MERGE,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] pos;
  } find_t;

endpackage

// ----- sv/buddy_block_allocator_unit.sv -----
// channel | ports                                               | direction
// in      | in_valid, in_stall, in_operation, in_request_bytes,  | request in
//         | in_user_address                                     |
// out     | out_valid, out_stall, out_status,                   | result out
//         | out_granted_address, out_granted_level              |
//
// An allocate searches upward, then splits down to the wanted level; a free merges upward; both
// move one free-map level per cycle. Zero, oversize or bad frees go straight to S_FINISH.
// Reset (rst_n low, synchronous) frees the top block at once; no clearing pass.
// The level RAM is not cleared; per-block taken bits guard it.
// A finished result waits in the output register; the next request is taken
// meanwhile, and only the final hand-off waits on out_stall.
module buddy_block_allocator_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic [bba_pkg::BYTES_W-1:0]    in_request_bytes,
  input  logic [bba_pkg::ADDR_W-1:0]     in_user_address,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bba_pkg::STATUS_W-1:0]   out_status,
  output logic [bba_pkg::ADDR_W-1:0]     out_granted_address,
  output logic [bba_pkg::LVL_W-1:0]      out_granted_level
);

  import bba_pkg::*;

  localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(NUM_LEVELS - 1);

  state_t state_r, state_nxt;

  logic             op_r, zero_r, over_r, bad_r;
  logic [LVL_W-1:0] want_r;
  logic [IDX_W-1:0] first_r;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic [MIN_BLOCKS-1:0] lvl_map_r [NUM_LEVELS];
  logic [MIN_BLOCKS-1:0] taken_r;

  status_t           res_status_r, res_status_nxt;
  logic [ADDR_W-1:0] res_addr_r, res_addr_nxt;
  logic [LVL_W-1:0]  res_level_r, res_level_nxt;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [LVL_W-1:0]  out_level_r;
  logic              out_free;

  logic [TOTAL_W-1:0] total;
  logic [LVL_W-1:0]   dec_want;
  logic               dec_over, dec_bad;
  logic [ADDR_W-1:0]  offset;
  logic [IDX_W-1:0]   dec_first;

  find_t            find;
  logic             buddy_free;
  logic [IDX_W-1:0] grant_first;
  logic [ADDR_W-1:0] grant_addr;

  logic             map_we, map_val;
  logic [LVL_W-1:0] map_lvl;
  logic [IDX_W-1:0] map_idx;
  logic             tk_we, tk_val;
  logic [IDX_W-1:0] tk_idx;
  logic             ram_we;
  logic [LVL_W-1:0] ram_rdata;

  // request decode
  always_comb begin
    total    = TOTAL_W'(in_request_bytes) + TOTAL_W'(HEADER_BYTES);
    dec_want = '0;
    dec_over = 1'b1;
    for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
      if ((32'd1 << (MIN_SHIFT + l)) >= 32'(total)) begin
        dec_want = LVL_W'(l);
        dec_over = 1'b0;
      end
    end
    offset    = in_user_address - ADDR_W'(HEADER_BYTES);
    dec_bad   = (in_user_address < ADDR_W'(HEADER_BYTES)) ||
                (32'(offset) >= POOL_BYTES) ||
                (offset[MIN_SHIFT-1:0] != '0);
    dec_first = offset[MIN_SHIFT +: IDX_W];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r    <= in_operation;
      zero_r  <= (in_request_bytes == '0);
      over_r  <= dec_over;
      want_r  <= dec_want;
      bad_r   <= dec_bad;
      first_r <= dec_first;
    end
  end

  bba_ffs u_find (
    .vec (lvl_map_r[lvl_r]),
    .res (find)
  );

  assign buddy_free  = lvl_map_r[lvl_r][idx_r ^ IDX_W'(1)];
  assign grant_first = idx_r << want_r;
  assign grant_addr  = ADDR_W'({grant_first, MIN_SHIFT'(0)}) + ADDR_W'(HEADER_BYTES);

  bba_ram #(
    .WIDTH (LVL_W),
    .DEPTH (MIN_BLOCKS)
  ) u_level_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (grant_first),
    .wdata (want_r),
    .raddr (first_r),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_START;
      end
      S_START: begin
        if (op_r == OP_ALLOC) begin
          state_nxt = (zero_r || over_r) ? S_FINISH : S_SEARCH;
        end else begin
          state_nxt = (bad_r || !taken_r[first_r]) ? S_FINISH : S_LOOKUP;
        end
      end
      S_SEARCH: begin
        if (find.found) begin
          state_nxt = (lvl_r == want_r) ? S_GRANT : S_SPLIT;
        end else if (lvl_r == TOP_LVL) begin
          state_nxt = S_FINISH;
        end
      end
      S_SPLIT: begin
        if (lvl_r - LVL_W'(1) == want_r) state_nxt = S_GRANT;
      end
      S_GRANT:  state_nxt = S_FINISH;
      S_LOOKUP: state_nxt = S_MERGE;
      S_MERGE: begin
        if (!(lvl_r != TOP_LVL && buddy_free)) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    lvl_nxt        = lvl_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_addr_nxt   = res_addr_r;
    res_level_nxt  = res_level_r;
    map_we         = 1'b0;
    map_val        = 1'b0;
    map_lvl        = lvl_r;
    map_idx        = idx_r;
    tk_we          = 1'b0;
    tk_val         = 1'b0;
    tk_idx         = first_r;
    ram_we         = 1'b0;
    unique case (state_r)
      S_START: begin
        lvl_nxt        = want_r;
        idx_nxt        = '0;
        res_addr_nxt   = '0;
        res_level_nxt  = '0;
        res_status_nxt = ST_DONE;
        if (op_r == OP_ALLOC) begin
          if (zero_r) res_status_nxt = ST_ZERO;
          else if (over_r) res_status_nxt = ST_NOFIT;
        end
      end
      S_SEARCH: begin
        if (find.found) begin
          map_we  = 1'b1;
          map_idx = find.pos;
          idx_nxt = find.pos;
        end else if (lvl_r == TOP_LVL) begin
          res_status_nxt = ST_NOFIT;
          res_addr_nxt   = '0;
          res_level_nxt  = '0;
        end else begin
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
      S_SPLIT: begin
        lvl_nxt = lvl_r - LVL_W'(1);
        idx_nxt = idx_r << 1;
        map_we  = 1'b1;
        map_val = 1'b1;
        map_lvl = lvl_r - LVL_W'(1);
        map_idx = (idx_r << 1) | IDX_W'(1);
      end
      S_GRANT: begin
        tk_we          = 1'b1;
        tk_val         = 1'b1;
        tk_idx         = grant_first;
        ram_we         = 1'b1;
        res_status_nxt = ST_DONE;
        res_addr_nxt   = grant_addr;
        res_level_nxt  = want_r;
      end
      S_LOOKUP: begin
        lvl_nxt = ram_rdata;
        idx_nxt = first_r >> ram_rdata;
        tk_we   = 1'b1;
      end
      S_MERGE: begin
        map_we = 1'b1;
        if (lvl_r != TOP_LVL && buddy_free) begin
          map_idx = idx_r ^ IDX_W'(1);
          idx_nxt = idx_r >> 1;
          lvl_nxt = lvl_r + LVL_W'(1);
        end else begin
          map_val        = 1'b1;
          res_status_nxt = ST_DONE;
          res_addr_nxt   = '0;
          res_level_nxt  = lvl_r;
        end
      end
      S_IDLE, S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      taken_r     <= '0;
      for (int l = 0; l < NUM_LEVELS - 1; l++) begin
        lvl_map_r[l] <= '0;
      end
      lvl_map_r[NUM_LEVELS-1] <= MIN_BLOCKS'(1);
    end else begin
      state_r <= state_nxt;
      if (map_we) lvl_map_r[map_lvl][map_idx] <= map_val;
      if (tk_we) taken_r[tk_idx] <= tk_val;
      if (state_r == S_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_addr_r   <= res_addr_nxt;
    res_level_r  <= res_level_nxt;
    if (state_r == S_FINISH && out_free) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
      out_level_r  <= res_level_r;
    end
  end

  assign in_stall            = (state_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_address = out_addr_r;
  assign out_granted_level   = out_level_r;

  a_search_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SEARCH |-> lvl_r >= want_r)
    else $error("search below wanted level");

  a_split_lvl: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SPLIT |-> lvl_r > want_r)
    else $error("split at or below wanted level");

  a_merge_taken: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MERGE |-> !taken_r[first_r])
    else $error("merging a block still marked taken");

  a_top_map: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_map_r[NUM_LEVELS-1] >> 1) == '0)
    else $error("top level holds more than one block");

  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FINISH && out_free |=> out_valid)
    else $error("finished request not presented");

endmodule

// ----- sv/bba_ram.sv -----
module bba_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/bba_ffs.sv -----
module bba_ffs (
  input  logic [bba_pkg::MIN_BLOCKS-1:0] vec,
  output bba_pkg::find_t                 res
);

  import bba_pkg::*;

  // lowest set bit wins
  always_comb begin
    res.found = 1'b0;
    res.pos   = '0;
    for (int i = MIN_BLOCKS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        res.found = 1'b1;
        res.pos   = IDX_W'(i);
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import bba_pkg::*;

  localparam int ITEM_TOTAL  = 1850;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int MAX_FIT     = POOL_BYTES - HEADER_BYTES;
  localparam int MAP_NODES   = (1 << NUM_LEVELS) - 1;

  typedef struct {
    status_t             st;
    logic [ADDR_W-1:0]   addr;
    logic [LVL_W-1:0]    lvl;
  } grant_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_operation = 1'b0;
  logic [BYTES_W-1:0]    in_request_bytes = '0;
  logic [ADDR_W-1:0]     in_user_address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [ADDR_W-1:0]     out_granted_address;
  logic [LVL_W-1:0]      out_granted_level;

  // predictor state
  bit                    free_map [MAP_NODES];
  logic [LVL_W-1:0]      block_lvl [MIN_BLOCKS];
  bit                    block_taken [MIN_BLOCKS];

  grant_t                pending_grants [$];
  int                    live_addrs [$];

  bit                    quiet = 1'b0;
  bit                    hold_long = 1'b0;
  int                    mismatches = 0;
  int                    requests_sent = 0;
  int                    n_grants = 0;
  int                    n_refused = 0;
  int                    n_top_merges = 0;
  int                    in_stall_cycles = 0;
  int                    cycles = 0;

  buddy_block_allocator_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (in_operation),
    .in_request_bytes    (in_request_bytes),
    .in_user_address     (in_user_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_address (out_granted_address),
    .out_granted_level   (out_granted_level)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int map_node(int lvl, int idx);
    return ((1 << (NUM_LEVELS - 1 - lvl)) - 1) + idx;
  endfunction

  function automatic void reset_pool();
    foreach (free_map[k]) free_map[k] = 1'b0;
    foreach (block_taken[k]) begin
      block_taken[k] = 1'b0;
      block_lvl[k] = '0;
    end
    free_map[map_node(NUM_LEVELS - 1, 0)] = 1'b1;
  endfunction

  function automatic grant_t buddy_predict(op_t op, int bytes, int addr);
    grant_t r;
    int total, want, lvl, idx, first, offset;
    bit found;
    r.st = ST_DONE;
    r.addr = '0;
    r.lvl = '0;
    found = 1'b0;
    lvl = 0;
    idx = 0;
    if (op == OP_ALLOC) begin
      if (bytes == 0) begin
        r.st = ST_ZERO;
        return r;
      end
      total = bytes + HEADER_BYTES;
      want = 0;
      while (want < NUM_LEVELS && (1 << (MIN_SHIFT + want)) < total) want++;
      if (want >= NUM_LEVELS) begin
        r.st = ST_NOFIT;
        return r;
      end
      for (int l = want; l < NUM_LEVELS && !found; l++) begin
        for (int i = 0; i < (1 << (NUM_LEVELS - 1 - l)) && !found; i++) begin
          if (free_map[map_node(l, i)]) begin
            found = 1'b1;
            lvl = l;
            idx = i;
          end
        end
      end
      if (!found) begin
        r.st = ST_NOFIT;
        return r;
      end
      free_map[map_node(lvl, idx)] = 1'b0;
      while (lvl > want) begin
        lvl--;
        idx = idx << 1;
        free_map[map_node(lvl, idx + 1)] = 1'b1;
      end
      first = (idx << lvl) & (MIN_BLOCKS - 1);
      block_taken[first] = 1'b1;
      block_lvl[first] = LVL_W'(want);
      r.addr = ADDR_W'((first << MIN_SHIFT) + HEADER_BYTES);
      r.lvl = LVL_W'(want);
      return r;
    end
    if (addr < HEADER_BYTES) return r;
    offset = addr - HEADER_BYTES;
    if (offset >= POOL_BYTES || (offset & ((1 << MIN_SHIFT) - 1)) != 0) return r;
    first = offset >> MIN_SHIFT;
    if (first >= MIN_BLOCKS || !block_taken[first]) return r;
    lvl = block_lvl[first];
    block_taken[first] = 1'b0;
    idx = first >> lvl;
    while (lvl < NUM_LEVELS - 1 && free_map[map_node(lvl, idx ^ 1)]) begin
      free_map[map_node(lvl, idx ^ 1)] = 1'b0;
      idx = idx >> 1;
      lvl++;
    end
    free_map[map_node(lvl, idx)] = 1'b1;
    r.lvl = LVL_W'(lvl);
    return r;
  endfunction

  // entered and left at a falling edge
  task automatic send_req(op_t op, int bytes, int addr);
    int gap;
    grant_t g;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_request_bytes <= BYTES_W'(bytes);
    in_user_address  <= ADDR_W'(addr);
    do @(posedge clk); while (in_stall !== 1'b0);
    g = buddy_predict(op, bytes, addr);
    pending_grants.push_back(g);
    requests_sent++;
    if (g.st != ST_DONE) n_refused++;
    if (op == OP_ALLOC && g.st == ST_DONE) begin
      live_addrs.push_back(g.addr);
      n_grants++;
    end
    if (op == OP_FREE) begin
      if (g.lvl == LVL_W'(NUM_LEVELS - 1)) n_top_merges++;
      for (int k = 0; k < live_addrs.size(); k++) begin
        if (live_addrs[k] == addr) begin
          live_addrs.delete(k);
          break;
        end
      end
    end
    @(negedge clk);
  endtask

  task automatic free_live(int k);
    send_req(OP_FREE, $urandom_range(0, 8191), live_addrs[k]);
  endtask

  task automatic free_all_live();
    while (live_addrs.size() > 0) free_live($urandom_range(0, live_addrs.size() - 1));
  endtask

  task automatic test_size_limits();
    send_req(OP_ALLOC, 0, 4095);
    send_req(OP_ALLOC, 8191, 0);
    send_req(OP_ALLOC, MAX_FIT + 1, 0);
    send_req(OP_ALLOC, MAX_FIT, 0);
    send_req(OP_ALLOC, 1, 0);
    send_req(OP_FREE, 0, HEADER_BYTES);
  endtask

  task automatic test_split_merge();
    send_req(OP_ALLOC, 8, 0);
    send_req(OP_ALLOC, 9, 0);
    send_req(OP_ALLOC, 40, 0);
    send_req(OP_ALLOC, 104, 0);
    free_live(1);
    free_live(0);
    free_live(1);
    free_live(0);
  endtask

  task automatic test_bad_frees();
    send_req(OP_FREE, 8191, 0);
    send_req(OP_FREE, 0, HEADER_BYTES - 1);
    send_req(OP_FREE, 0, HEADER_BYTES + 1);
    send_req(OP_FREE, 0, 4095);
    send_req(OP_FREE, 0, HEADER_BYTES + 32);
    send_req(OP_ALLOC, 8, 0);
    send_req(OP_FREE, 0, HEADER_BYTES);
    send_req(OP_FREE, 0, HEADER_BYTES);
  endtask

  // result side holds off while requests keep coming, so the input backs up
  task automatic test_backpressure();
    quiet = 1'b1;
    hold_long = 1'b1;
    for (int k = 0; k < 12; k++) send_req(OP_ALLOC, $urandom_range(1, 40), 0);
    quiet = 1'b0;
    free_all_live();
  endtask

  task automatic test_random_traffic();
    int r, lv, lo, hi, n;
    n = 0;
    while (requests_sent < ITEM_TOTAL) begin
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (n % 150 == 149) free_all_live();
      r = $urandom_range(0, 99);
      if (r < 45 || (r < 85 && live_addrs.size() == 0)) begin
        lv = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3)
                                         : $urandom_range(0, NUM_LEVELS - 1);
        hi = (1 << (MIN_SHIFT + lv)) - HEADER_BYTES;
        lo = (lv == 0) ? 1 : (1 << (MIN_SHIFT + lv - 1)) - HEADER_BYTES + 1;
        send_req(OP_ALLOC, $urandom_range(lo, hi), $urandom_range(0, 4095));
      end else if (r < 85) begin
        free_live($urandom_range(0, live_addrs.size() - 1));
      end else if (r < 90) begin
        send_req(OP_FREE, $urandom_range(0, 8191), $urandom_range(0, 4095));
      end else if (r < 94) begin
        send_req(OP_FREE, $urandom_range(0, 8191),
                 $urandom_range(0, MIN_BLOCKS - 1) * 32 + HEADER_BYTES);
      end else if (r < 97) begin
        send_req(OP_ALLOC, 0, $urandom_range(0, 4095));
      end else begin
        send_req(OP_ALLOC, $urandom_range(MAX_FIT + 1, 8191), $urandom_range(0, 4095));
      end
      n++;
    end
    quiet = 1'b0;
  endtask

  initial begin : result_sink
    int w;
    forever begin
      w = quiet ? 0 : $urandom_range(0, 6);
      if (hold_long) begin
        w = LONG_HOLD;
        hold_long = 1'b0;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected result: status %0d address %0d level %0d",
               out_status, out_granted_address, out_granted_level);
        mismatches++;
      end else begin
        g = pending_grants.pop_front();
        if (out_status !== g.st) begin
          $error("status: expected %0d, got %0d", g.st, out_status);
          mismatches++;
        end
        if (out_granted_address !== g.addr) begin
          $error("granted_address: expected %0d, got %0d", g.addr, out_granted_address);
          mismatches++;
        end
        if (out_granted_level !== g.lvl) begin
          $error("granted_level: expected %0d, got %0d", g.lvl, out_granted_level);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (in_valid && in_stall === 1'b1) in_stall_cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    reset_pool();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_size_limits();
    test_split_merge();
    test_bad_frees();
    test_backpressure();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (pending_grants.size() != 0) mismatches++;
    $display("Sent %0d requests: %0d grants, %0d refused, %0d frees back to the full pool",
             requests_sent, n_grants, n_refused, n_top_merges);
    $display("Input held off %0d cycles under result backpressure; %0d mismatches",
             in_stall_cycles, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/bba_pkg.sv
sv/bba_ram.sv
sv/bba_ffs.sv
sv/buddy_block_allocator_unit.sv
dv/tb_top.sv
